>>> src/tfcp_pkg.sv
// Shared types and codes for the TLV frame checker and parser.
package tfcp_pkg;

   // Kind of one frame byte, also the parse phase
   typedef enum logic [2:0] {
      KIND_START   = 3'd0,
      KIND_ADDR    = 3'd1,
      KIND_LEN     = 3'd2,
      KIND_CHECK   = 3'd3,
      KIND_CMD     = 3'd4,
      KIND_TAG     = 3'd5,
      KIND_TLEN    = 3'd6,
      KIND_VALUE   = 3'd7
   } kind_type;

   // Frame verdict codes
   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_BAD_START = 3'd1,
      STATUS_WRONG_DST = 3'd2,
      STATUS_LEN_BAD   = 3'd3,
      STATUS_LRC_BAD   = 3'd4,
      STATUS_SHORT     = 3'd5
   } status_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_DEVICE_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_START_MARKER   = 2'd1;

   localparam logic [8:0] COUNT_MAX = 9'd511;
   localparam logic [8:0] MIN_FRAME = 9'd5;
   localparam logic [7:0] TLV_MAX   = 8'd255;

   // Per-frame parse state
   typedef struct packed {
      logic [8:0] byte_counter;
      logic [7:0] running_sum;
      kind_type   parse_phase;
      logic [7:0] value_bytes_left;
      logic [7:0] tlv_counter;
      logic [1:0] header_flags;
      logic [7:0] declared_length;
      logic [3:0] sender_nibble;
      logic [7:0] current_tlv;
   } frame_state_type;

   localparam frame_state_type FRAME_RESET = '{
      byte_counter:     9'd0,
      running_sum:      8'd0,
      parse_phase:      KIND_START,
      value_bytes_left: 8'd0,
      tlv_counter:      8'd0,
      header_flags:     2'd0,
      declared_length:  8'd0,
      sender_nibble:    4'd0,
      current_tlv:      8'd0
   };

   // One result item
   typedef struct packed {
      kind_type   byte_kind;
      logic [7:0] byte_value;
      logic [7:0] tlv_index;
      logic       frame_done;
      status_type frame_status;
      logic [3:0] source_address;
      logic [7:0] tlv_total;
      logic       truncated;
   } result_type;

endpackage

>>> src/tlv_frame_checker_parser_core.sv
// Top level of the TLV frame checker and parser with a two-deep result buffer.
// An accepted byte's result item is registered into the output register when it is
// free, else into the skid register, and waits there while it stays unaccepted.
// Throughput: one byte per cycle while the skid register is empty.
// A second result register lets a byte be accepted while a result waits.
// Synchronous active-high reset clears frame state, configuration registers and valid flags.
module tlv_frame_checker_parser_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_byte_kind,
   output logic [7:0] rsp_byte_value,
   output logic [7:0] rsp_tlv_index,
   output logic       rsp_frame_done,
   output logic [2:0] rsp_frame_status,
   output logic [3:0] rsp_source_address,
   output logic [7:0] rsp_tlv_total,
   output logic       rsp_truncated
);

   logic [3:0]                device_address_ff;
   logic [7:0]                start_marker_ff;
   tfcp_pkg::frame_state_type frame_ff, frame_in;
   tfcp_pkg::result_type      result_in;
   tfcp_pkg::result_type      out_ff, skid_ff;
   logic                      out_valid_ff, skid_valid_ff;
   logic                      push, pop;

   tfcp_step u_step (
      .state_i        (frame_ff),
      .data_byte      (req_data_byte),
      .last_byte      (req_last_byte),
      .device_address (device_address_ff),
      .start_marker   (start_marker_ff),
      .state_o        (frame_in),
      .result_o       (result_in)
   );

   assign req_ready = !skid_valid_ff;
   assign push      = req_valid && req_ready;
   assign pop       = out_valid_ff && rsp_ready;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= 4'd0;
         start_marker_ff   <= 8'd0;
      end else if (csr_we) begin
         if (csr_index == tfcp_pkg::CSR_DEVICE_ADDRESS)
            device_address_ff <= csr_wdata[3:0];
         else if (csr_index == tfcp_pkg::CSR_START_MARKER)
            start_marker_ff <= csr_wdata;
      end
   end

   // Advance the frame state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= tfcp_pkg::FRAME_RESET;
      end else if (push) begin
         frame_ff <= frame_in;
      end
   end

   // Output register with a skid stage behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_ff       <= result_in;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= result_in;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_byte_kind      = out_ff.byte_kind;
   assign rsp_byte_value     = out_ff.byte_value;
   assign rsp_tlv_index      = out_ff.tlv_index;
   assign rsp_frame_done     = out_ff.frame_done;
   assign rsp_frame_status   = out_ff.frame_status;
   assign rsp_source_address = out_ff.source_address;
   assign rsp_tlv_total      = out_ff.tlv_total;
   assign rsp_truncated      = out_ff.truncated;

endmodule

>>> src/tfcp_step.sv
// Per-byte parse step: next frame state and the result item for one byte.
module tfcp_step (
   input  tfcp_pkg::frame_state_type state_i,
   input  logic [7:0]                data_byte,
   input  logic                      last_byte,
   input  logic [3:0]                device_address,
   input  logic [7:0]                start_marker,
   output tfcp_pkg::frame_state_type state_o,
   output tfcp_pkg::result_type      result_o
);

   tfcp_pkg::frame_state_type nxt;
   logic [7:0]                idx;
   logic                      len_match;

   // Advance the parse phase and label the byte
   always_comb begin
      nxt = state_i;
      idx = 8'd0;
      unique case (state_i.parse_phase)
         tfcp_pkg::KIND_START: begin
            if (data_byte != start_marker) nxt.header_flags[0] = 1'b1;
            nxt.parse_phase = tfcp_pkg::KIND_ADDR;
         end
         tfcp_pkg::KIND_ADDR: begin
            if (data_byte[3:0] != device_address) nxt.header_flags[1] = 1'b1;
            nxt.sender_nibble = data_byte[7:4];
            nxt.parse_phase   = tfcp_pkg::KIND_LEN;
         end
         tfcp_pkg::KIND_LEN: begin
            nxt.declared_length = data_byte;
            nxt.parse_phase     = tfcp_pkg::KIND_CHECK;
         end
         tfcp_pkg::KIND_CHECK: nxt.parse_phase = tfcp_pkg::KIND_CMD;
         tfcp_pkg::KIND_CMD:   nxt.parse_phase = tfcp_pkg::KIND_TAG;
         tfcp_pkg::KIND_TAG: begin
            nxt.current_tlv = state_i.tlv_counter;
            if (state_i.tlv_counter != tfcp_pkg::TLV_MAX)
               nxt.tlv_counter = state_i.tlv_counter + 8'd1;
            idx             = state_i.tlv_counter;
            nxt.parse_phase = tfcp_pkg::KIND_TLEN;
         end
         tfcp_pkg::KIND_TLEN: begin
            idx                  = state_i.current_tlv;
            nxt.value_bytes_left = data_byte;
            nxt.parse_phase      = (data_byte != 8'd0) ? tfcp_pkg::KIND_VALUE
                                                       : tfcp_pkg::KIND_TAG;
         end
         tfcp_pkg::KIND_VALUE: begin
            idx = state_i.current_tlv;
            if (state_i.value_bytes_left <= 8'd1) begin
               nxt.value_bytes_left = 8'd0;
               nxt.parse_phase      = tfcp_pkg::KIND_TAG;
            end else begin
               nxt.value_bytes_left = state_i.value_bytes_left - 8'd1;
            end
         end
         default: nxt = state_i;
      endcase

      // Count bytes with saturation, accumulate the LRC sum
      if (state_i.byte_counter != tfcp_pkg::COUNT_MAX)
         nxt.byte_counter = state_i.byte_counter + 9'd1;
      nxt.running_sum = state_i.running_sum + data_byte;
   end

   assign len_match = (nxt.byte_counter == {1'b0, nxt.declared_length});

   // Build the result and return to the idle frame state after the last byte
   always_comb begin
      result_o                = '0;
      result_o.byte_kind      = state_i.parse_phase;
      result_o.byte_value     = data_byte;
      result_o.tlv_index      = idx;
      result_o.frame_done     = last_byte;
      result_o.frame_status   = tfcp_pkg::STATUS_OK;
      state_o                 = nxt;
      if (last_byte) begin
         priority if (nxt.byte_counter < tfcp_pkg::MIN_FRAME)
            result_o.frame_status = tfcp_pkg::STATUS_SHORT;
         else if (nxt.header_flags[0])
            result_o.frame_status = tfcp_pkg::STATUS_BAD_START;
         else if (nxt.header_flags[1])
            result_o.frame_status = tfcp_pkg::STATUS_WRONG_DST;
         else if (!len_match)
            result_o.frame_status = tfcp_pkg::STATUS_LEN_BAD;
         else if (nxt.running_sum != 8'd0)
            result_o.frame_status = tfcp_pkg::STATUS_LRC_BAD;
         else
            result_o.frame_status = tfcp_pkg::STATUS_OK;
         result_o.source_address = nxt.sender_nibble;
         result_o.tlv_total      = nxt.tlv_counter;
         result_o.truncated      = (nxt.byte_counter >= tfcp_pkg::MIN_FRAME) &&
                                   ((nxt.parse_phase == tfcp_pkg::KIND_TLEN) ||
                                    (nxt.parse_phase == tfcp_pkg::KIND_VALUE));
         state_o = tfcp_pkg::FRAME_RESET;
      end
   end

endmodule

>>> src/tfcp_checker.sv
// Port-level assertions for the TLV frame checker and parser, with its bind.
module tfcp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_byte_kind,
   input logic [7:0] rsp_byte_value,
   input logic [7:0] rsp_tlv_index,
   input logic       rsp_frame_done,
   input logic [2:0] rsp_frame_status,
   input logic [3:0] rsp_source_address,
   input logic [7:0] rsp_tlv_total,
   input logic       rsp_truncated
);

   // Verdict fields stay zero on bytes that do not end a frame
   a_verdict_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_done) |->
      (rsp_frame_status == tfcp_pkg::STATUS_OK && rsp_source_address == 4'd0 &&
       rsp_tlv_total == 8'd0 && !rsp_truncated))
      else $error("verdict fields set on a byte that is not last");

   // A frame rejected as too short is never flagged as truncated
   a_short_not_trunc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_truncated) |->
      (rsp_frame_status != tfcp_pkg::STATUS_SHORT))
      else $error("short frame flagged as truncated");

   // Header bytes belong to no TLV
   a_header_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_byte_kind != tfcp_pkg::KIND_TAG &&
       rsp_byte_kind != tfcp_pkg::KIND_TLEN &&
       rsp_byte_kind != tfcp_pkg::KIND_VALUE) |-> (rsp_tlv_index == 8'd0))
      else $error("header byte carries a TLV index");

   // Hold a stalled result item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_byte_value) && $stable(rsp_byte_kind) &&
       $stable(rsp_frame_done)))
      else $error("stalled result item changed");

endmodule

bind tlv_frame_checker_parser_core tfcp_checker u_tfcp_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_byte_kind      (rsp_byte_kind),
   .rsp_byte_value     (rsp_byte_value),
   .rsp_tlv_index      (rsp_tlv_index),
   .rsp_frame_done     (rsp_frame_done),
   .rsp_frame_status   (rsp_frame_status),
   .rsp_source_address (rsp_source_address),
   .rsp_tlv_total      (rsp_tlv_total),
   .rsp_truncated      (rsp_truncated)
);
